// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk with the synchronous reset as disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define CHK_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication checked with its consequent in the cycle after the antecedent
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/fmba_pkg.sv =====
package fmba_pkg;

  localparam int POOL_BYTES        = 65536;
  localparam int USED_HEADER_BYTES = 16;
  localparam int FREE_HEADER_BYTES = 48;
  localparam int MAX_BLOCKS        = 64;

  localparam int OFF_W  = 16;
  localparam int SIZE_W = $clog2(POOL_BYTES + 1);
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int LEVELS = $clog2(MAX_BLOCKS);
  localparam int NODES  = 1 << LEVELS;
  localparam int LVL_W  = $clog2(LEVELS + 1);

  typedef logic [OFF_W-1:0]  start_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_NOTOCC = 3'd3,
    ST_NULL   = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic reduce;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic bypass;
  } stat_t;

endpackage

// ===== hdl/fit_mode_block_allocator.sv =====
// Allocator over one byte pool kept as an address-ordered table of up to 64 blocks.
// Requests enter on s_*, one at a time. An allocate or a free request goes from
// acceptance through the per-block compares, the compare tree and the commit to
// its result on m_*; a free request rejected by its null or bounds check skips
// the tree. The registered six-level compare tree picks the block, one level per
// cycle, after the per-block compares and before the table is rewritten at commit.
// The next request is taken once the result has been delivered. The mode register
// at address 0 selects first (0), best (1) or worst (2) fit; 3 acts as first fit.
module fit_mode_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes[15:0], user_offset[31:16]
  input  logic [1:0]  s_tuser,   // opcode[0], is_null[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[2:0], result_offset[18:3], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmba_pkg::*;
  `include "assert_macros.svh"

  logic [1:0] place_mode;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      place_mode <= MODE_FIRST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      place_mode <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, place_mode};

  fmba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  fmba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .place_mode (place_mode),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .m_tdata    (m_tdata)
  );

  `CHK_IMPL(a_one_in_flight, m_tvalid, !s_tready, "request accepted while a result waits")
  `CHK_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second request taken at once")
  `CHK_NEXT(a_ready_after_result, m_tvalid && m_tready, s_tready, "not ready after delivery")
  `CHK_IMPL(a_offset_only_ok, m_tvalid && (m_tdata[2:0] != ST_OK), m_tdata[18:3] == 16'd0,
            "nonzero offset on a failed request")
  `CHK_IMPL(a_status_range, m_tvalid, m_tdata[2:0] <= ST_NULL, "status code out of range")

endmodule

// ===== hdl/fmba_ctrl.sv =====
module fmba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output fmba_pkg::cmd_t cmd,
  input  fmba_pkg::stat_t stat
);
  import fmba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RED,
    S_COMMIT,
    S_RESP
  } state_t;

  state_t             state;
  logic [LVL_W-1:0]   lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EVAL;
        end
        S_EVAL: begin
          lvl   <= '0;
          state <= stat.bypass ? S_COMMIT : S_RED;
        end
        S_RED: begin
          lvl <= lvl + 1'b1;
          if (lvl == LVL_W'(LEVELS - 1)) state <= S_COMMIT;
        end
        S_COMMIT: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (m_tready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready   = (state == S_IDLE);
  assign m_tvalid   = (state == S_RESP);
  assign cmd.load   = (state == S_IDLE) && s_tvalid;
  assign cmd.eval   = (state == S_EVAL);
  assign cmd.reduce = (state == S_RED);
  assign cmd.commit = (state == S_COMMIT);

endmodule

// ===== hdl/fmba_dp.sv =====
module fmba_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      place_mode,
  input  logic [31:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  input  fmba_pkg::cmd_t  cmd,
  output fmba_pkg::stat_t stat,
  output logic [23:0]     m_tdata
);
  import fmba_pkg::*;

  typedef struct packed {
    logic   vld;
    size_t  size;
    idx_t   idx;
    start_t start;
    logic   lf;
    logic   rf;
  } node_t;

  // request registers
  op_t    req_op;
  start_t req_bytes;
  start_t req_user;
  logic   req_null;

  // block table
  start_t cstart [MAX_BLOCKS];
  size_t  csize  [MAX_BLOCKS];
  logic   cocc   [MAX_BLOCKS];
  cnt_t   ccount;

  node_t   node [NODES];
  status_t early;
  status_t out_status;
  start_t  out_offset;

  // table padded by one cell below, marked occupied, and two free cells above
  start_t ext_start [MAX_BLOCKS+3];
  size_t  ext_size  [MAX_BLOCKS+3];
  logic   ext_occ   [MAX_BLOCKS+3];

  size_t  needed;
  start_t head;
  logic [1:0] mode;
  node_t  win;
  size_t  rem;
  logic   split;
  idx_t   tgt;
  logic [1:0] merge_cnt;
  logic   do_alloc;
  logic   do_free;

  always_comb begin
    ext_start[0] = '0;
    ext_size[0]  = '0;
    ext_occ[0]   = 1'b1;
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      ext_start[j+1] = cstart[j];
      ext_size[j+1]  = csize[j];
      ext_occ[j+1]   = cocc[j];
    end
    for (int j = MAX_BLOCKS + 1; j < MAX_BLOCKS + 3; j++) begin
      ext_start[j] = '0;
      ext_size[j]  = '0;
      ext_occ[j]   = 1'b0;
    end
  end

  assign needed = SIZE_W'(req_bytes) + SIZE_W'(USED_HEADER_BYTES);
  assign head   = req_user - OFF_W'(USED_HEADER_BYTES);
  // code 3 matches neither best nor worst and so acts as first fit
  assign mode   = (req_op == OP_FREE) ? MODE_FIRST : place_mode;

  always_comb begin
    early = ST_OK;
    if (req_op == OP_FREE) begin
      if (req_null) early = ST_NULL;
      else if (SIZE_W'(req_user) >= SIZE_W'(POOL_BYTES)) early = ST_RANGE;
      else if (req_user < OFF_W'(USED_HEADER_BYTES)) early = ST_NOTOCC;
    end
  end
  assign stat.bypass = (early != ST_OK);

  assign win       = node[0];
  assign rem       = win.size - needed;
  assign split     = (rem >= SIZE_W'(FREE_HEADER_BYTES)) && (ccount < CNT_W'(MAX_BLOCKS));
  assign tgt       = win.idx - IDX_W'(win.lf);
  assign merge_cnt = {1'b0, win.lf} + {1'b0, win.rf};
  assign do_alloc  = cmd.commit && !stat.bypass && win.vld && (req_op == OP_ALLOC);
  assign do_free   = cmd.commit && !stat.bypass && win.vld && (req_op == OP_FREE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= op_t'(s_tuser[0]);
      req_null  <= s_tuser[1];
      req_bytes <= s_tdata[15:0];
      req_user  <= s_tdata[31:16];
    end

    if (cmd.eval) begin
      for (int j = 0; j < NODES; j++) begin
        if (j < MAX_BLOCKS) begin
          node[j].idx   <= IDX_W'(j);
          node[j].start <= ext_start[j+1];
          node[j].lf    <= (j > 0) && !ext_occ[j];
          node[j].rf    <= (CNT_W'(j + 1) < ccount) && !ext_occ[j+2];
          if (req_op == OP_ALLOC) begin
            node[j].vld  <= (CNT_W'(j) < ccount) && !ext_occ[j+1]
                            && (ext_size[j+1] >= needed);
            node[j].size <= ext_size[j+1];
          end else begin
            node[j].vld  <= (CNT_W'(j) < ccount) && ext_occ[j+1]
                            && (ext_start[j+1] == head);
            // size after merging with free neighbors
            node[j].size <= ext_size[j+1]
                            + (((j > 0) && !ext_occ[j]) ? ext_size[j] : '0)
                            + (((CNT_W'(j + 1) < ccount) && !ext_occ[j+2])
                               ? ext_size[j+2] : '0);
          end
        end else begin
          node[j] <= '0;
        end
      end
    end

    if (cmd.reduce) begin
      for (int k = 0; k < NODES / 2; k++) begin
        if ((!node[2*k].vld && node[2*k+1].vld)
            || (node[2*k].vld && node[2*k+1].vld
                && (((mode == MODE_BEST) && (node[2*k+1].size < node[2*k].size))
                    || ((mode == MODE_WORST) && (node[2*k+1].size > node[2*k].size)))))
          node[k] <= node[2*k+1];
        else
          node[k] <= node[2*k];
      end
    end

    if (cmd.commit) begin
      if (stat.bypass) begin
        out_status <= early;
        out_offset <= '0;
      end else if (!win.vld) begin
        out_status <= (req_op == OP_FREE) ? ST_NOTOCC : ST_NOFIT;
        out_offset <= '0;
      end else begin
        out_status <= ST_OK;
        out_offset <= (req_op == OP_ALLOC) ? win.start + OFF_W'(USED_HEADER_BYTES) : '0;
      end
    end

    if (rst) begin
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        cstart[j] <= '0;
        csize[j]  <= (j == 0) ? SIZE_W'(POOL_BYTES) : '0;
        cocc[j]   <= 1'b0;
      end
      ccount   <= CNT_W'(1);
    end else if (do_alloc) begin
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        if (IDX_W'(j) == win.idx) begin
          cocc[j] <= 1'b1;
          if (split) csize[j] <= needed;
        end else if (split && (IDX_W'(j) == win.idx + 1'b1) && (j > 0)) begin
          cstart[j] <= win.start + OFF_W'(needed);
          csize[j]  <= rem;
          cocc[j]   <= 1'b0;
        end else if (split && (j > 0) && (IDX_W'(j) > win.idx + 1'b1)) begin
          cstart[j] <= ext_start[j];
          csize[j]  <= ext_size[j];
          cocc[j]   <= ext_occ[j];
        end
      end
      if (split) ccount <= ccount + 1'b1;
    end else if (do_free) begin
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        if (IDX_W'(j) == tgt) begin
          csize[j] <= win.size;
          cocc[j]  <= 1'b0;
        end else if ((IDX_W'(j) > tgt) && (merge_cnt == 2'd1)) begin
          cstart[j] <= ext_start[j+2];
          csize[j]  <= ext_size[j+2];
          cocc[j]   <= ext_occ[j+2];
        end else if ((IDX_W'(j) > tgt) && (merge_cnt == 2'd2)) begin
          cstart[j] <= ext_start[j+3];
          csize[j]  <= ext_size[j+3];
          cocc[j]   <= ext_occ[j+3];
        end
      end
      ccount <= ccount - CNT_W'(merge_cnt);
    end
  end

  assign m_tdata = {5'b0, out_offset, out_status};

endmodule
